// ===== design/stsm_pkg.sv =====
// Shared widths, types and constants for the structure tensor slope mask block.
package stsm_pkg;

    localparam int XX_W       = 31;
    localparam int XY_W       = 32;
    localparam int COH_W      = 17;
    localparam int SLOPE_W    = 32;
    localparam int LIM_W      = 31;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 2;

    localparam int DM_W   = 31;
    localparam int SM_W   = 33;
    localparam int RAD_W  = 66;
    localparam int ROOT_W = 33;
    localparam int NUM_W  = 52;
    localparam int DEN_W  = 35;
    localparam int CMP_W  = 66;
    localparam int QUO_W  = 31;

    localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASK_EN   = 2'd0,
        CFG_COH_THR   = 2'd1,
        CFG_SLOPE_LIM = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             mask_en;
        logic [COH_W-1:0] coh_thr;
        logic [LIM_W-1:0] slope_lim;
    } t_cfg;

    typedef struct packed {
        logic             xy_zero;
        logic             d_neg;
        logic             xy_neg;
        logic [COH_W-1:0] coh;
    } t_tag;

    typedef struct packed {
        t_tag            tag;
        logic [DM_W-1:0] dm;
        logic [SM_W-1:0] sm;
    } t_sq_side;

endpackage

// ===== design/stsm_in_if.sv =====
// Input channel interface: tensor components and coherence of one pixel.
interface stsm_in_if;
    logic                              valid;
    logic                              ready;
    logic        [stsm_pkg::XX_W-1:0]  tensor_xx;
    logic signed [stsm_pkg::XY_W-1:0]  tensor_xy;
    logic        [stsm_pkg::XX_W-1:0]  tensor_yy;
    logic        [stsm_pkg::COH_W-1:0] pixel_coherence;

    modport source (output valid, tensor_xx, tensor_xy, tensor_yy, pixel_coherence,
                    input ready);
    modport sink   (input valid, tensor_xx, tensor_xy, tensor_yy, pixel_coherence,
                    output ready);
endinterface

// ===== design/stsm_out_if.sv =====
// Output channel interface: slope and masked flag of one pixel.
interface stsm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [stsm_pkg::SLOPE_W-1:0] slope_value;
    logic                                masked_flag;

    modport source (output valid, slope_value, masked_flag, input ready);
    modport sink   (input valid, slope_value, masked_flag, output ready);
endinterface

// ===== design/stsm_prep.sv =====
// Front stages: difference, magnitudes, squares and the square root radicand.
module stsm_prep (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic        [stsm_pkg::XX_W-1:0]  i_xx,
    input  logic        [stsm_pkg::XY_W-1:0]  i_xy,
    input  logic        [stsm_pkg::XX_W-1:0]  i_yy,
    input  logic        [stsm_pkg::COH_W-1:0] i_coh,
    output logic                              o_vld,
    output logic        [stsm_pkg::RAD_W-1:0] o_rad,
    output stsm_pkg::t_sq_side                o_side
);
    localparam int DW  = stsm_pkg::XY_W;
    localparam int DMW = stsm_pkg::DM_W;
    localparam int DDW = 2 * stsm_pkg::DM_W;
    localparam int X2W = 2 * stsm_pkg::XY_W;
    localparam int RW  = stsm_pkg::RAD_W;

    logic [DW-1:0]      n_d;
    logic [DW-1:0]      n_xm;
    stsm_pkg::t_sq_side n_side;

    logic               r_a_vld;
    logic [DW-1:0]      r_a_xm;
    stsm_pkg::t_sq_side r_a_side;
    logic               r_b_vld;
    logic [DDW-1:0]     r_b_dd;
    logic [X2W-1:0]     r_b_xx2;
    stsm_pkg::t_sq_side r_b_side;
    logic               r_c_vld;
    logic [RW-1:0]      r_c_rad;
    stsm_pkg::t_sq_side r_c_side;

    always_comb begin
        n_d                = {1'b0, i_yy} - {1'b0, i_xx};
        n_xm               = i_xy[DW-1] ? (DW'(0) - i_xy) : i_xy;
        n_side.tag.xy_zero = (i_xy == '0);
        n_side.tag.d_neg   = n_d[DW-1];
        n_side.tag.xy_neg  = i_xy[DW-1];
        n_side.tag.coh     = i_coh;
        n_side.dm          = DMW'(n_d[DW-1] ? (DW'(0) - n_d) : n_d);
        n_side.sm          = {n_xm, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_xm   <= n_xm;
            r_a_side <= n_side;
            r_b_dd   <= DDW'(r_a_side.dm) * DDW'(r_a_side.dm);
            r_b_xx2  <= X2W'(r_a_xm) * X2W'(r_a_xm);
            r_b_side <= r_a_side;
            r_c_rad  <= RW'(r_b_dd) + {r_b_xx2, 2'b00};
            r_c_side <= r_b_side;
        end
    end

    assign o_vld  = r_c_vld;
    assign o_rad  = r_c_rad;
    assign o_side = r_c_side;
endmodule

// ===== design/stsm_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module stsm_sqrt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  logic        [stsm_pkg::RAD_W-1:0]  i_rad,
    input  stsm_pkg::t_sq_side                 i_side,
    output logic                               o_vld,
    output logic        [stsm_pkg::ROOT_W-1:0] o_root,
    output stsm_pkg::t_sq_side                 o_side
);
    localparam int RW = stsm_pkg::RAD_W;
    localparam int QW = stsm_pkg::ROOT_W;

    logic               r_vld  [QW];
    logic [RW-1:0]      r_rem  [QW];
    logic [QW-1:0]      r_root [QW];
    stsm_pkg::t_sq_side r_side [QW];

    genvar j;
    for (j = 0; j < QW; j++) begin : g_stg
        localparam int K = QW - 1 - j;

        logic               vld_in;
        logic [RW-1:0]      rem_in;
        logic [QW-1:0]      root_in;
        stsm_pkg::t_sq_side side_in;
        logic [RW-1:0]      trial;
        logic               fits;
        logic [RW-1:0]      n_rem;
        logic [QW-1:0]      n_root;

        if (j == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = i_rad;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[j-1];
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign side_in = r_side[j-1];
        end

        // (root + 2^K)^2 - root^2
        assign trial  = (RW'(root_in) << (K + 1)) | (RW'(1) << (2 * K));
        assign fits   = (rem_in >= trial);
        assign n_rem  = fits ? (rem_in - trial) : rem_in;
        assign n_root = fits ? (root_in | (QW'(1) << K)) : root_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_root = r_root[QW-1];
    assign o_side = r_side[QW-1];
endmodule

// ===== design/stsm_div.sv =====
// Operand setup and pipelined restoring divider with rounding and overflow detect.
module stsm_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  logic        [stsm_pkg::ROOT_W-1:0] i_root,
    input  stsm_pkg::t_sq_side                 i_side,
    output logic                               o_vld,
    output logic        [stsm_pkg::QUO_W-1:0]  o_quo,
    output logic                               o_sat,
    output stsm_pkg::t_tag                     o_tag
);
    localparam int NW  = stsm_pkg::NUM_W;
    localparam int DNW = stsm_pkg::DEN_W;
    localparam int CW  = stsm_pkg::CMP_W;
    localparam int QW  = stsm_pkg::QUO_W;
    localparam int SW  = DNW - 1;
    localparam int PW  = SW + 16;

    logic [SW-1:0]  n_rsum;
    logic [SW-1:0]  n_den;
    logic [PW-1:0]  n_num;
    logic [NW-1:0]  n_n;
    logic [DNW-1:0] n_dd;
    logic           n_sat;

    logic           r_e_vld;
    logic [NW-1:0]  r_e_rem;
    logic [DNW-1:0] r_e_den;
    logic           r_e_sat;
    stsm_pkg::t_tag r_e_tag;

    logic           r_vld [QW];
    logic [NW-1:0]  r_rem [QW];
    logic [DNW-1:0] r_den [QW];
    logic [QW-1:0]  r_quo [QW];
    logic           r_sat [QW];
    stsm_pkg::t_tag r_tag [QW];

    // rounded quotient: (2*num + den) / (2*den)
    always_comb begin
        n_rsum = SW'(i_root) + SW'(i_side.dm);
        if (i_side.tag.d_neg) begin
            n_num = {n_rsum, 16'h0000};
            n_den = SW'(i_side.sm);
        end else begin
            n_num = PW'({i_side.sm, 16'h0000});
            n_den = n_rsum;
        end
        n_n   = NW'({n_num, 1'b0}) + NW'(n_den);
        n_dd  = {n_den, 1'b0};
        n_sat = (CW'(n_n) >= {n_dd, {QW{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_e_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_rem <= n_n;
            r_e_den <= n_dd;
            r_e_sat <= n_sat;
            r_e_tag <= i_side.tag;
        end
    end

    genvar j;
    for (j = 0; j < QW; j++) begin : g_stg
        localparam int K = QW - 1 - j;

        logic           vld_in;
        logic [NW-1:0]  rem_in;
        logic [DNW-1:0] den_in;
        logic [QW-1:0]  quo_in;
        logic           sat_in;
        stsm_pkg::t_tag tag_in;
        logic [CW-1:0]  dsh;
        logic           fits;
        logic [NW-1:0]  n_rem;

        if (j == 0) begin : g_first
            assign vld_in = r_e_vld;
            assign rem_in = r_e_rem;
            assign den_in = r_e_den;
            assign quo_in = '0;
            assign sat_in = r_e_sat;
            assign tag_in = r_e_tag;
        end else begin : g_next
            assign vld_in = r_vld[j-1];
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
            assign sat_in = r_sat[j-1];
            assign tag_in = r_tag[j-1];
        end

        assign dsh   = CW'(den_in) << K;
        assign fits  = (CW'(rem_in) >= dsh);
        assign n_rem = fits ? (rem_in - NW'(dsh)) : rem_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_den[j] <= den_in;
                r_quo[j] <= fits ? (quo_in | (QW'(1) << K)) : quo_in;
                r_sat[j] <= sat_in;
                r_tag[j] <= tag_in;
            end
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_quo = r_quo[QW-1];
    assign o_sat = r_sat[QW-1];
    assign o_tag = r_tag[QW-1];
endmodule

// ===== design/stsm_post.sv =====
// Sign, saturation, special cases, masking and the output register with skid entry.
module stsm_post (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic        [stsm_pkg::QUO_W-1:0]   i_quo,
    input  logic                                i_sat,
    input  stsm_pkg::t_tag                      i_tag,
    input  stsm_pkg::t_cfg                      i_cfg,
    input  logic                                i_out_rdy,
    output logic                                o_en,
    output logic                                o_out_vld,
    output logic        [stsm_pkg::SLOPE_W-1:0] o_slope,
    output logic                                o_masked
);
    localparam int SW = stsm_pkg::SLOPE_W;
    localparam int EW = SW + 1;

    logic [SW-1:0] slope;
    logic [EW-1:0] s_ext;
    logic [EW-1:0] lim_ext;
    logic [EW-1:0] nlim_ext;
    logic          mask_on;
    logic          out_range;
    logic          low_coh;
    logic          n_masked;
    logic [SW-1:0] n_slope;
    logic          take;

    logic          r_out_vld;
    logic [SW-1:0] r_out_slope;
    logic          r_out_masked;
    logic          r_sk_vld;
    logic [SW-1:0] r_sk_slope;
    logic          r_sk_masked;

    always_comb begin
        if (i_tag.xy_zero) begin
            slope = i_tag.d_neg ? stsm_pkg::SLOPE_MAX : '0;
        end else if (i_tag.xy_neg) begin
            slope = i_sat ? stsm_pkg::SLOPE_MIN : (SW'(0) - {1'b0, i_quo});
        end else begin
            slope = i_sat ? stsm_pkg::SLOPE_MAX : {1'b0, i_quo};
        end
        s_ext     = {slope[SW-1], slope};
        lim_ext   = {2'b00, i_cfg.slope_lim};
        nlim_ext  = EW'(0) - lim_ext;
        mask_on   = i_cfg.mask_en && (i_cfg.coh_thr != '0) && (i_cfg.slope_lim != '0);
        out_range = ($signed(s_ext) > $signed(lim_ext)) || ($signed(s_ext) < $signed(nlim_ext));
        low_coh   = (i_tag.coh < i_cfg.coh_thr);
        n_masked  = mask_on && (out_range || low_coh);
        n_slope   = n_masked ? nlim_ext[SW-1:0] : slope;
    end

    assign o_en = !r_sk_vld;
    assign take = r_out_vld && i_out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_sk_vld  <= 1'b0;
        end else if (r_sk_vld) begin
            if (take) begin
                r_out_slope  <= r_sk_slope;
                r_out_masked <= r_sk_masked;
                r_sk_vld     <= 1'b0;
            end
        end else if (i_vld) begin
            if (!r_out_vld || take) begin
                r_out_slope  <= n_slope;
                r_out_masked <= n_masked;
                r_out_vld    <= 1'b1;
            end else begin
                r_sk_slope  <= n_slope;
                r_sk_masked <= n_masked;
                r_sk_vld    <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_vld = r_out_vld;
    assign o_slope   = r_out_slope;
    assign o_masked  = r_out_masked;
endmodule

// ===== design/structure_tensor_slope_mask_top.sv =====
// Top level of the structure tensor slope mask block.
// Takes one pixel transaction per clock while the input is ready and returns one
// slope transaction per pixel, in order, through three setup stages (difference,
// two multipliers, radicand add), a 33-stage square root that resolves one root
// bit per stage, one divider setup stage, a 31-stage divider that resolves one
// quotient bit per stage, and the output register. A skid entry behind the output
// register keeps the input ready while one finished result waits; ready drops only
// once that entry is occupied. Configuration writes are taken on any cycle with
// i_cfg_we high and should be made while no transaction is in flight.
module structure_tensor_slope_mask_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    stsm_in_if.sink                                i_pix,
    stsm_out_if.source                             o_slope,
    input  logic                                   i_cfg_we,
    input  logic        [stsm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [stsm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CW = stsm_pkg::COH_W;

    stsm_pkg::t_cfg     r_cfg;

    logic                            en;
    logic                            pre_vld;
    logic [stsm_pkg::RAD_W-1:0]      pre_rad;
    stsm_pkg::t_sq_side              pre_side;
    logic                            sq_vld;
    logic [stsm_pkg::ROOT_W-1:0]     sq_root;
    stsm_pkg::t_sq_side              sq_side;
    logic                            dv_vld;
    logic [stsm_pkg::QUO_W-1:0]      dv_quo;
    logic                            dv_sat;
    stsm_pkg::t_tag                  dv_tag;
    logic [stsm_pkg::SLOPE_W-1:0]    out_slope;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (stsm_pkg::t_cfg_idx'(i_cfg_idx))
                stsm_pkg::CFG_MASK_EN:   r_cfg.mask_en   <= i_cfg_data[0];
                stsm_pkg::CFG_COH_THR:   r_cfg.coh_thr   <= i_cfg_data[CW-1:0];
                stsm_pkg::CFG_SLOPE_LIM: r_cfg.slope_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_pix.ready = en;

    stsm_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_pix.valid),
        .i_xx    (i_pix.tensor_xx),
        .i_xy    (i_pix.tensor_xy),
        .i_yy    (i_pix.tensor_yy),
        .i_coh   (i_pix.pixel_coherence),
        .o_vld   (pre_vld),
        .o_rad   (pre_rad),
        .o_side  (pre_side)
    );

    stsm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (pre_vld),
        .i_rad   (pre_rad),
        .i_side  (pre_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    stsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_sat   (dv_sat),
        .o_tag   (dv_tag)
    );

    stsm_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (dv_vld),
        .i_quo     (dv_quo),
        .i_sat     (dv_sat),
        .i_tag     (dv_tag),
        .i_cfg     (r_cfg),
        .i_out_rdy (o_slope.ready),
        .o_en      (en),
        .o_out_vld (o_slope.valid),
        .o_slope   (out_slope),
        .o_masked  (o_slope.masked_flag)
    );

    assign o_slope.slope_value = out_slope;
endmodule

// ===== design/stsm_check.sv =====
// Port-level assertions for the structure tensor slope mask block and their binding.
module stsm_check (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_rdy,
    input logic                                i_out_vld,
    input logic                                i_out_rdy,
    input logic        [stsm_pkg::SLOPE_W-1:0] i_slope,
    input logic                                i_masked
);
    localparam int SW = stsm_pkg::SLOPE_W;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && !i_out_rdy |=> i_out_vld && $stable(i_slope) && $stable(i_masked))
        else $error("output transaction changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_vld)
        else $error("output valid after reset");

    // the skid entry fills only when the output stalls
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_vld || i_out_rdy |=> i_in_rdy)
        else $error("input not ready although output was not stalled");

    // a masked slope is minus a nonzero limit
    a_mask_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && i_masked |-> i_slope[SW-1])
        else $error("masked transaction with non-negative slope");
endmodule

bind structure_tensor_slope_mask_top stsm_check u_stsm_check (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_in_rdy  (i_pix.ready),
    .i_out_vld (o_slope.valid),
    .i_out_rdy (o_slope.ready),
    .i_slope   (o_slope.slope_value),
    .i_masked  (o_slope.masked_flag)
);
